@@ hdl/gld_pkg.sv @@
package gld_pkg;

	localparam int MAX_CODE_BITS_DEF = 12;
	localparam int STACK_DEPTH_DEF   = 4096;
	localparam logic [3:0] MIN_SIZE_RESET = 4'd8;

	typedef enum logic [1:0] {
		OP_PUSH    = 2'd0,
		OP_PULL    = 2'd1,
		OP_RESTART = 2'd2,
		OP_NOP     = 2'd3
	} opcode_t;

	// Code size after clamping to the legal range of two to nine.
	function automatic logic [3:0] eff_size(input logic [3:0] s);
		logic [3:0] r;
		r = s;
		if (s < 4'd2) begin
			r = 4'd2;
		end else if (s > 4'd9) begin
			r = 4'd9;
		end
		return r;
	endfunction

endpackage

@@ hdl/gld_core.sv @@
module gld_core import gld_pkg::*; #(
	parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF,
	parameter int STACK_DEPTH   = STACK_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata,
	input  logic       start,
	input  logic [1:0] op,
	input  logic [7:0] din,
	output logic       done,
	output logic       r_accepted,
	output logic       r_byte_valid,
	output logic [7:0] r_out_byte,
	output logic       r_last,
	output logic       r_need_data,
	output logic       r_ended,
	output logic       r_errored
);

	localparam int TW = MAX_CODE_BITS;
	localparam int TS = 1 << TW;
	localparam int SW = $clog2(STACK_DEPTH);
	localparam int CW = SW + 1;
	localparam int NW = TW + 1;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CHAIN = 6'b000010,
		ST_WAIT  = 6'b000100,
		ST_FIN   = 6'b001000,
		ST_POP   = 6'b010000,
		ST_POPW  = 6'b100000
	} state_t;

	state_t state_q;

	logic [TW-1:0] prefix_mem [TS];
	logic [7:0]    suffix_mem [TS];
	logic [7:0]    stack_mem  [STACK_DEPTH];

	logic [3:0]    min_size_q;
	logic [19:0]   bitbuf_q;
	logic [4:0]    held_q;
	logic [3:0]    width_q;
	logic [NW-1:0] next_free_q;
	logic [TW-1:0] prev_code_q;
	logic [7:0]    prev_first_q;
	logic [CW-1:0] count_q;
	logic          ended_q, errored_q;
	logic [TW-1:0] code_q;
	logic [TW-1:0] c_q;
	logic [NW-1:0] steps_q;
	logic [TW-1:0] pre_rd_q;
	logic [7:0]    suf_rd_q;
	logic [7:0]    stk_rd_q;

	logic [3:0]    esz;
	logic [NW-1:0] clr, first;
	logic [TW-1:0] code_now;
	logic [19:0]   code_mask;

	assign esz       = eff_size(min_size_q);
	assign clr       = NW'(1) << esz;
	assign first     = clr + NW'(2);
	assign code_mask = (20'd1 << width_q) - 20'd1;
	assign code_now  = TW'(bitbuf_q & code_mask);

	// Stack write port and table write port.
	logic          stk_we;
	logic [7:0]    stk_wd;
	logic          tab_we;
	logic [TW-1:0] tab_rd_addr;

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stack_mem[count_q[SW-1:0]] <= stk_wd;
		end
		stk_rd_q <= stack_mem[SW'(count_q - CW'(1))];
		if (tab_we) begin
			prefix_mem[next_free_q[TW-1:0]] <= prev_code_q;
			suffix_mem[next_free_q[TW-1:0]] <= c_q[7:0];
		end
		pre_rd_q <= prefix_mem[tab_rd_addr];
		suf_rd_q <= suffix_mem[tab_rd_addr];
	end

	logic chain_go;
	assign chain_go   = ({1'b0, c_q} >= first) && (steps_q < NW'(TS));
	assign tab_rd_addr = c_q;

	always_comb begin
		stk_we = 1'b0;
		stk_wd = suf_rd_q;
		tab_we = 1'b0;
		if (state_q == ST_IDLE && start && op == OP_PULL && count_q == '0 &&
		    !ended_q && !errored_q && {1'b0, held_q} >= {2'b0, width_q} &&
		    {1'b0, code_now} != clr && {1'b0, code_now} != clr + NW'(1) &&
		    {1'b0, code_now} == next_free_q && prev_code_q != clr[TW-1:0]) begin
			stk_we = count_q < CW'(STACK_DEPTH);
			stk_wd = prev_first_q;
		end
		if (state_q == ST_WAIT) begin
			stk_we = count_q < CW'(STACK_DEPTH);
			stk_wd = suf_rd_q;
		end
		if (state_q == ST_FIN) begin
			stk_we = count_q < CW'(STACK_DEPTH);
			stk_wd = c_q[7:0];
			tab_we = prev_code_q != clr[TW-1:0] && next_free_q < NW'(TS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			min_size_q   <= MIN_SIZE_RESET;
			bitbuf_q     <= '0;
			held_q       <= '0;
			width_q      <= MIN_SIZE_RESET + 4'd1;
			next_free_q  <= (NW'(1) << MIN_SIZE_RESET) + NW'(2);
			prev_code_q  <= TW'(1) << MIN_SIZE_RESET;
			prev_first_q <= '0;
			count_q      <= '0;
			ended_q      <= 1'b0;
			errored_q    <= 1'b0;
			done         <= 1'b0;
			r_accepted   <= 1'b0;
			r_byte_valid <= 1'b0;
			r_out_byte   <= '0;
			r_last       <= 1'b0;
			code_q       <= '0;
			c_q          <= '0;
			steps_q      <= '0;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				min_size_q   <= cfg_wdata;
				bitbuf_q     <= '0;
				held_q       <= '0;
				width_q      <= eff_size(cfg_wdata) + 4'd1;
				next_free_q  <= (NW'(1) << eff_size(cfg_wdata)) + NW'(2);
				prev_code_q  <= TW'(1) << eff_size(cfg_wdata);
				prev_first_q <= '0;
				count_q      <= '0;
				ended_q      <= 1'b0;
				errored_q    <= 1'b0;
			end else begin
				case (state_q)
					ST_IDLE: begin
						if (start) begin
							r_accepted   <= 1'b0;
							r_byte_valid <= 1'b0;
							r_out_byte   <= '0;
							r_last       <= 1'b0;
							case (op)
								OP_PUSH: begin
									if (!ended_q && !errored_q && {1'b0, held_q} < {2'b0, width_q}) begin
										bitbuf_q   <= bitbuf_q | (20'(din) << held_q);
										held_q     <= held_q + 5'd8;
										r_accepted <= 1'b1;
									end
									done <= 1'b1;
								end
								OP_PULL: begin
									if (count_q == '0 && !ended_q && !errored_q &&
									    {1'b0, held_q} >= {2'b0, width_q}) begin
										bitbuf_q <= bitbuf_q >> width_q;
										held_q   <= held_q - {1'b0, width_q};
										code_q   <= code_now;
										steps_q  <= '0;
										if ({1'b0, code_now} == clr) begin
											width_q     <= esz + 4'd1;
											next_free_q <= first;
											prev_code_q <= clr[TW-1:0];
											done        <= 1'b1;
										end else if ({1'b0, code_now} == clr + NW'(1)) begin
											ended_q <= 1'b1;
											done    <= 1'b1;
										end else if ({1'b0, code_now} > next_free_q ||
										    ({1'b0, code_now} == next_free_q &&
										     prev_code_q == clr[TW-1:0])) begin
											errored_q <= 1'b1;
											done      <= 1'b1;
										end else begin
											if ({1'b0, code_now} == next_free_q) begin
												c_q <= prev_code_q;
												if (stk_we) count_q <= count_q + CW'(1);
											end else begin
												c_q <= code_now;
											end
											state_q <= ST_CHAIN;
										end
									end else if (count_q != '0) begin
										state_q <= ST_POP;
									end else begin
										done <= 1'b1;
									end
								end
								OP_RESTART: begin
									bitbuf_q     <= '0;
									held_q       <= '0;
									width_q      <= esz + 4'd1;
									next_free_q  <= first;
									prev_code_q  <= clr[TW-1:0];
									prev_first_q <= '0;
									count_q      <= '0;
									ended_q      <= 1'b0;
									errored_q    <= 1'b0;
									done         <= 1'b1;
								end
								default: begin
									done <= 1'b1;
								end
							endcase
						end
					end
					ST_CHAIN: begin
						// Table read issued at c_q this cycle.
						state_q <= chain_go ? ST_WAIT : ST_FIN;
					end
					ST_WAIT: begin
						if (stk_we) count_q <= count_q + CW'(1);
						c_q     <= pre_rd_q;
						steps_q <= steps_q + NW'(1);
						state_q <= ST_CHAIN;
					end
					ST_FIN: begin
						c_q <= {{(TW-8){1'b0}}, c_q[7:0]};
						if (stk_we) count_q <= count_q + CW'(1);
						if (tab_we) begin
							next_free_q <= next_free_q + NW'(1);
							if ((next_free_q + NW'(1)) >= (NW'(1) << width_q) &&
							    width_q < 4'(TW)) begin
								width_q <= width_q + 4'd1;
							end
						end
						prev_code_q  <= code_q;
						prev_first_q <= c_q[7:0];
						state_q      <= ST_POPW;
					end
					ST_POPW: begin
						state_q <= ST_POP;
					end
					ST_POP: begin
						count_q      <= count_q - CW'(1);
						r_byte_valid <= 1'b1;
						r_out_byte   <= stk_rd_q;
						r_last       <= count_q == CW'(1);
						done         <= 1'b1;
						state_q      <= ST_IDLE;
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	assign r_need_data = count_q == '0 && {1'b0, held_q} < {2'b0, width_q};
	assign r_ended     = ended_q;
	assign r_errored   = errored_q;

endmodule

@@ hdl/gif_lzw_decoder.sv @@
// GIF-style LZW decoder with variable code width up to MAX_CODE_BITS bits.
// Input channel (in_valid/in_ready) carries one word: an opcode and a byte.
// A push word offers a compressed byte to the bit buffer, a pull word
// returns at most one decoded byte, and a restart word returns the stream
// state to its start. Every input word yields exactly one output word on
// the out_valid/out_ready channel, carrying the status flags, unless cfg_we
// is written in the cycle the word is accepted. For a push, restart,
// no-op, or a pull that meets a clear, end or bad code, the core registers
// done as the word is accepted, and done sets the registered out_valid. A
// pull served from the string stack passes through ST_POP, which takes the
// registered stack read. A pull that decodes a string walks the prefix chain
// through the synchronous prefix and suffix memories, alternating ST_CHAIN
// and ST_WAIT per step, then passes ST_FIN, ST_POPW and ST_POP.
// The block handles one word at a time. The output word is held in a
// register until taken, so a stalled receiver simply holds the block.
// Reset clears all control state and sets the minimum code size to eight;
// the tables are not cleared because decoding never reads an entry before
// writing it. Writing min_code_size also restarts the decoder.
module gif_lzw_decoder import gld_pkg::*; #(
	parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF,
	parameter int STACK_DEPTH   = STACK_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] opcode,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       accepted,
	output logic       byte_valid,
	output logic [7:0] out_byte,
	output logic       last_of_string,
	output logic       need_data,
	output logic       stream_ended,
	output logic       code_error
);

	// Busy from acceptance until the result word is taken.
	logic busy_q;
	logic done;
	logic start;

	assign in_ready = !busy_q;
	assign start    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
			end
			if (done) begin
				out_valid <= 1'b1;
			end
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
				busy_q    <= 1'b0;
			end
		end
	end

	gld_core #(
		.MAX_CODE_BITS(MAX_CODE_BITS),
		.STACK_DEPTH  (STACK_DEPTH)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.start       (start),
		.op          (opcode),
		.din         (data_byte),
		.done        (done),
		.r_accepted  (accepted),
		.r_byte_valid(byte_valid),
		.r_out_byte  (out_byte),
		.r_last      (last_of_string),
		.r_need_data (need_data),
		.r_ended     (stream_ended),
		.r_errored   (code_error)
	);

endmodule

@@ sim/tb_gif_lzw_decoder.sv @@
`timescale 1ns / 1ps

module tb_gif_lzw_decoder import gld_pkg::*; ();

	// One output word of the decoder, in port order.
	typedef struct packed {
		logic       accepted;
		logic       byte_valid;
		logic [7:0] out_byte;
		logic       last_of_string;
		logic       need_data;
		logic       stream_ended;
		logic       code_error;
	} status_t;

	// One row of the directed table. Rows with typed set carry their expected
	// word; the others are checked against the decoder model below.
	typedef struct packed {
		opcode_t    op;
		logic [7:0] data;
		logic       typed;
		status_t    want;
	} dir_row_t;

	localparam int TBL_SIZE   = 4096;
	localparam int MAX_WIDTH  = 12;
	localparam int IDLE_LIMIT = 30000;
	localparam int CFG_SETTLE = 40;
	localparam int DIR_ROWS   = 16;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [3:0] cfg_wdata = 4'd0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] opcode = OP_NOP;
	logic [7:0] data_byte = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       accepted;
	logic       byte_valid;
	logic [7:0] out_byte;
	logic       last_of_string;
	logic       need_data;
	logic       stream_ended;
	logic       code_error;

	gif_lzw_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.accepted(accepted),
		.byte_valid(byte_valid),
		.out_byte(out_byte),
		.last_of_string(last_of_string),
		.need_data(need_data),
		.stream_ended(stream_ended),
		.code_error(code_error)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Decoder model. It mirrors the block's architectural state: the bit
	// buffer, the code width, the dictionary, and the stack of string bytes
	// that a pull hands out last byte pushed first.
	// ------------------------------------------------------------------
	logic [3:0]  size_reg;
	logic [19:0] bits;
	int          nbits;
	int          width;
	int          free_code;
	int          last_code;
	logic [7:0]  last_first;
	int          prefix_mem [TBL_SIZE];
	logic [7:0]  suffix_mem [TBL_SIZE];
	logic [7:0]  str_stack [TBL_SIZE];
	int          depth;
	bit          saw_end;
	bit          saw_bad;

	function automatic int clamp_size(input logic [3:0] s);
		if (s < 4'd2) begin
			return 2;
		end
		if (s > 4'd9) begin
			return 9;
		end
		return int'(s);
	endfunction

	task automatic model_restart();
		int clr;
		clr = 1 << clamp_size(size_reg);
		bits = '0;
		nbits = 0;
		width = clamp_size(size_reg) + 1;
		free_code = clr + 2;
		last_code = clr;
		last_first = 8'd0;
		depth = 0;
		saw_end = 1'b0;
		saw_bad = 1'b0;
	endtask

	task automatic push_char(input logic [7:0] ch);
		if (depth < TBL_SIZE) begin
			str_stack[depth] = ch;
			depth++;
		end
	endtask

	// Expands one code onto the stack and grows the dictionary, or handles a clear, end or bad code.
	task automatic expand_code(input int code);
		int clr;
		int first;
		int walk;
		int steps;
		bit repeat_case;
		clr = 1 << clamp_size(size_reg);
		first = clr + 2;
		steps = 0;
		if (code == clr) begin
			width = clamp_size(size_reg) + 1;
			free_code = first;
			last_code = clr;
		end else if (code == clr + 1) begin
			saw_end = 1'b1;
		end else if (code > free_code || (code == free_code && last_code == clr)) begin
			saw_bad = 1'b1;
		end else begin
			// A code one past the dictionary is the previous string plus its
			// own first character.
			repeat_case = (code == free_code);
			walk = repeat_case ? last_code : code;
			if (repeat_case) begin
				push_char(last_first);
			end
			while (walk >= first && steps < TBL_SIZE) begin
				walk &= TBL_SIZE - 1;
				push_char(suffix_mem[walk]);
				walk = prefix_mem[walk];
				steps++;
			end
			walk &= 255;
			push_char(walk[7:0]);
			if (last_code != clr && free_code < TBL_SIZE) begin
				prefix_mem[free_code] = last_code & (TBL_SIZE - 1);
				suffix_mem[free_code] = walk[7:0];
				free_code++;
				if (free_code >= (1 << width) && width < MAX_WIDTH) begin
					width++;
				end
			end
			last_code = code;
			last_first = walk[7:0];
		end
	endtask

	task automatic model_word(input opcode_t op, input logic [7:0] data, output status_t res);
		int code;
		res = '0;
		case (op)
			OP_PUSH: begin
				if (!saw_end && !saw_bad && nbits < width) begin
					bits = bits | (20'(data) << nbits);
					nbits += 8;
					res.accepted = 1'b1;
				end
			end
			OP_PULL: begin
				if (depth == 0 && !saw_end && !saw_bad && nbits >= width) begin
					code = int'(bits) & ((1 << width) - 1);
					bits = bits >> width;
					nbits -= width;
					expand_code(code);
				end
				if (depth > 0) begin
					depth--;
					res.byte_valid = 1'b1;
					res.out_byte = str_stack[depth];
					res.last_of_string = (depth == 0);
				end
			end
			OP_RESTART: begin
				model_restart();
			end
			default: begin
			end
		endcase
		res.need_data = (depth == 0 && nbits < width);
		res.stream_ended = saw_end;
		res.code_error = saw_bad;
	endtask

	// ------------------------------------------------------------------
	// Expected words, checking and the run counters.
	// ------------------------------------------------------------------
	status_t pending_words[$];
	int      errors = 0;
	int      words_sent = 0;
	int      words_seen = 0;
	int      bytes_out = 0;
	int      ends_seen = 0;
	int      bad_seen = 0;
	int      streams = 0;
	int      sizes_used = 0;
	bit      quiet = 1'b0;
	bit      rx_hold = 1'b0;

	task automatic report(input string what, input int got, input int want);
		$display("MISMATCH word %0d %s: got %0d, expected %0d", words_seen, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		status_t w;
		if (out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				report("unexpected word", 1, 0);
			end else begin
				w = pending_words.pop_front();
				if (accepted !== w.accepted)
					report("accepted", accepted, w.accepted);
				if (byte_valid !== w.byte_valid)
					report("byte_valid", byte_valid, w.byte_valid);
				if (out_byte !== w.out_byte)
					report("out_byte", out_byte, w.out_byte);
				if (last_of_string !== w.last_of_string)
					report("last_of_string", last_of_string, w.last_of_string);
				if (need_data !== w.need_data)
					report("need_data", need_data, w.need_data);
				if (stream_ended !== w.stream_ended)
					report("stream_ended", stream_ended, w.stream_ended);
				if (code_error !== w.code_error)
					report("code_error", code_error, w.code_error);
				if (w.byte_valid)
					bytes_out++;
			end
			words_seen++;
		end
	end

	// The watchdog counts cycles in which neither channel moves a word.
	int still_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			still_cycles <= 0;
		end else if (still_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end else begin
			still_cycles <= still_cycles + 1;
		end
	end

	// Receiver: stalls a random number of cycles before each word, except in
	// quiet stretches, and holds off for a long stretch when asked so that
	// the block fills and stops taking input words.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (rx_hold) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				rx_hold = 1'b0;
			end
			stall = quiet ? 0 : $urandom_range(18);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// ------------------------------------------------------------------
	// Sender side.
	// ------------------------------------------------------------------

	// Works out the expected word, then offers the word until it is taken.
	task automatic send_word(input opcode_t op, input logic [7:0] data, input bit typed,
		input status_t want);
		status_t res;
		int gap;
		model_word(op, data, res);
		if (typed && res !== want) begin
			$display("MISMATCH directed row %0d: model disagrees with typed word", words_sent);
			errors++;
		end
		pending_words.push_back(typed ? want : res);
		gap = quiet ? 0 : $urandom_range(18);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		data_byte <= data;
		do @(posedge clk); while (!in_ready);
		words_sent++;
	endtask

	task automatic send(input opcode_t op, input logic [7:0] data);
		send_word(op, data, 1'b0, '0);
	endtask

	// Waits until every expected word has come back, then lets the block
	// settle before the next phase.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0) @(posedge clk);
		repeat (CFG_SETTLE) @(posedge clk);
	endtask

	task automatic write_size(input logic [3:0] s);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= s;
		@(posedge clk);
		cfg_we <= 1'b0;
		size_reg = s;
		model_restart();
		sizes_used++;
	endtask

	// Compressed stream under construction, packed least significant bit first.
	logic [7:0] comp_bytes[$];
	longint     pack_bits;
	int         pack_count;

	task automatic pack_code(input int code, input int w);
		pack_bits |= longint'(code) << pack_count;
		pack_count += w;
		while (pack_count >= 8) begin
			comp_bytes.push_back(pack_bits[7:0]);
			pack_bits >>= 8;
			pack_count -= 8;
		end
	endtask

	// Builds a legal code sequence for the current code size: literals,
	// dictionary references, the repeat-string case, occasional clears, and
	// optionally a bad code and an end code at the tail.
	task automatic build_stream(input int ncodes, input int lit_pct, input bit bad_tail,
		input bit end_tail);
		int es;
		int clr;
		int w;
		int nf;
		bit after_clear;
		int r;
		int code;
		es = clamp_size(size_reg);
		clr = 1 << es;
		w = es + 1;
		nf = clr + 2;
		after_clear = 1'b1;
		comp_bytes.delete();
		pack_bits = 0;
		pack_count = 0;
		if ($urandom_range(1))
			pack_code(clr, w);
		for (int i = 0; i < ncodes; i++) begin
			r = $urandom_range(99);
			if (r < 3 && i > 0) begin
				pack_code(clr, w);
				w = es + 1;
				nf = clr + 2;
				after_clear = 1'b1;
			end else begin
				if (after_clear || r < lit_pct || nf <= clr + 2)
					code = $urandom_range(clr - 1);
				else if (r < lit_pct + 8 && nf < TBL_SIZE)
					code = nf;
				else
					code = $urandom_range(nf - 1, clr + 2);
				pack_code(code, w);
				if (!after_clear && nf < TBL_SIZE) begin
					nf++;
					if (nf >= (1 << w) && w < MAX_WIDTH)
						w++;
				end
				after_clear = 1'b0;
			end
		end
		if (bad_tail && nf + 1 < (1 << w))
			pack_code(nf + 1 + $urandom_range((1 << w) - nf - 2), w);
		if (end_tail)
			pack_code(clr + 1, w);
		if (pack_count > 0)
			comp_bytes.push_back(pack_bits[7:0]);
	endtask

	// Feeds the stream, pulling whenever a whole code blocks the next byte,
	// with some extra pulls mixed in, then empties the decoder.
	task automatic play_stream(input int break_pct);
		logic [7:0] b;
		foreach (comp_bytes[i]) begin
			b = comp_bytes[i];
			if ($urandom_range(99) < break_pct)
				b = 8'($urandom);
			while (!saw_end && !saw_bad && nbits >= width)
				send(OP_PULL, 8'($urandom));
			if ($urandom_range(99) < 15)
				send(OP_PULL, 8'($urandom));
			send(OP_PUSH, b);
		end
		while (depth > 0 || (!saw_end && !saw_bad && nbits >= width))
			send(OP_PULL, 8'($urandom));
		if (saw_end)
			ends_seen++;
		if (saw_bad)
			bad_seen++;
		streams++;
	endtask

	// Unstructured words: every opcode and any byte.
	task automatic noise(input int n);
		for (int i = 0; i < n; i++)
			send(opcode_t'($urandom_range(3)), 8'($urandom));
	endtask

	dir_row_t dir_rows [DIR_ROWS] = '{
		// Pull and no-op on an empty decoder give nothing and ask for data.
		'{OP_PULL,    8'h00, 1'b1, '{1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0}},
		'{OP_NOP,     8'hFF, 1'b1, '{1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0}},
		// Two bytes form the clear code 256 in the low nine bits.
		'{OP_PUSH,    8'h00, 1'b1, '{1'b1, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0}},
		'{OP_PUSH,    8'h01, 1'b1, '{1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
		// A whole code waits, so this byte is refused.
		'{OP_PUSH,    8'hFF, 1'b1, '{1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0}},
		// The clear code yields no byte.
		'{OP_PULL,    8'h00, 1'b1, '{1'b0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0}},
		'{OP_PUSH,    8'hFF, 1'b0, '0},
		'{OP_PULL,    8'hFF, 1'b0, '0},
		'{OP_PUSH,    8'h80, 1'b0, '0},
		'{OP_PULL,    8'h00, 1'b0, '0},
		'{OP_PUSH,    8'hFE, 1'b0, '0},
		'{OP_PULL,    8'h00, 1'b0, '0},
		'{OP_PULL,    8'h00, 1'b0, '0},
		'{OP_RESTART, 8'hAA, 1'b0, '0},
		'{OP_PUSH,    8'h55, 1'b0, '0},
		'{OP_PULL,    8'h00, 1'b0, '0}
	};

	// Code sizes in the order the random phases visit them; zero, one and
	// fifteen exercise the clamping, two and nine the legal extremes.
	logic [3:0] size_plan [10] = '{4'd2, 4'd9, 4'd0, 4'd15, 4'd5, 4'd8, 4'd3, 4'd1, 4'd7, 4'd4};

	initial begin
		int target;
		int round;
		size_reg = MIN_SIZE_RESET;
		model_restart();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_word(dir_rows[i].op, dir_rows[i].data, dir_rows[i].typed, dir_rows[i].want);

		// Random part: well-formed streams with random content at several code
		// sizes, with some broken streams, bad codes and noise between them.
		target = words_sent + 260;
		round = 0;
		while (words_sent < target) begin
			write_size(size_plan[round % 10]);
			quiet = ($urandom_range(3) == 0);
			if (round == 2)
				rx_hold = 1'b1;
			build_stream($urandom_range(6, 40), 40, ($urandom_range(3) == 0),
				($urandom_range(1) == 1));
			play_stream((round % 4 == 3) ? 5 : 0);
			if ($urandom_range(2) == 0)
				noise($urandom_range(4, 12));
			if ($urandom_range(3) == 0) begin
				// Restart mid-session and decode a fresh stream at the same size.
				send(OP_RESTART, 8'($urandom));
				build_stream($urandom_range(4, 20), 50, 1'b0, 1'b1);
				play_stream(0);
			end
			round++;
		end

		// The sender stops until the block has returned every word.
		drain();

		// A longer stream at the smallest size, sent back to back, grows the
		// code width several times.
		write_size(4'd2);
		quiet = 1'b1;
		build_stream(50, 60, 1'b0, 1'b1);
		play_stream(0);
		quiet = 1'b0;

		// Leave the block at its reset size.
		write_size(MIN_SIZE_RESET);
		build_stream(20, 40, 1'b0, 1'b1);
		play_stream(0);
		noise(10);

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0) @(posedge clk);
		repeat (CFG_SETTLE) @(posedge clk);

		$display("Covered %0d words in %0d streams over %0d code-size writes.",
			words_sent, streams, sizes_used);
		$display("Decoded %0d bytes; %0d streams ended, %0d stopped on a bad code.",
			bytes_out, ends_seen, bad_seen);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hdl/gld_pkg.sv
hdl/gld_core.sv
hdl/gif_lzw_decoder.sv
sim/tb_gif_lzw_decoder.sv
